// ===== rtl/tbt_pkg.sv =====
// tbt_pkg: shared types and constants for the thermistor beta temperature unit
// used by thermistor_beta_temperature_unit; no dependencies
package tbt_pkg;

	// fixed-point constants of the beta equation
	localparam logic [31:0] LN2_Q24       = 32'd11629080;
	localparam logic [31:0] T0_X100       = 32'd29815;
	localparam logic [31:0] NUM_SCALE     = 32'd4293360;   // 144 * 29815
	localparam logic [31:0] RECIP_25      = 32'd1342178;   // ceil(2^25 / 25)
	localparam logic [14:0] OUT_MAX       = 15'h3FFF;
	localparam logic [14:0] OUT_MIN       = 15'h6000;
	localparam int          LOG_ITERS     = 20;
	localparam int          DIV_ITERS     = 64;

	// configuration register indexes
	localparam logic [1:0] REG_CAL_OFFSET = 2'd0;
	localparam logic [1:0] REG_BETA       = 2'd1;
	localparam logic [1:0] REG_SERIES     = 2'd2;
	localparam logic [1:0] REG_NOMINAL    = 2'd3;

	// sequencer states
	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_START = 11'b00000000010,
		ST_NORM  = 11'b00000000100,
		ST_SQR   = 11'b00000001000,
		ST_LN    = 11'b00000010000,
		ST_XMUL  = 11'b00000100000,
		ST_DCALC = 11'b00001000000,
		ST_DIV   = 11'b00010000000,
		ST_POST  = 11'b00100000000,
		ST_FIN   = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

endpackage

// ===== rtl/thermistor_beta_temperature_unit.sv =====
// thermistor_beta_temperature_unit: ntc thermistor divider to calibrated degrees F
// depends on tbt_pkg
//
// Usage:
//  sample channel: adc_sample with sample_valid / sample_stall. One item is
//  taken each cycle while the unit is idle; samples are summed in runs of
//  SAMPLES_PER_READING.
//  The last sample of a run starts the computation. A shared 32x32 multiplier
//  and a one-bit-per-cycle restoring divider, under a one-hot sequencer, form
//  four log2 values (normalizing, then squaring, each), the kelvin quotient
//  and the final scaling by 1/25 (one reciprocal multiply). A degenerate
//  divider skips the computation; other samples of a run do not stall.
//  sample_stall is high while the sequencer is busy.
//  result channel: temp_f_sixteenths and out_of_range with result_valid /
//  result_stall, held in an output register; sampling of the next run goes on
//  while a result waits, and a newly finished result waits for the register.
//  config channel: cfg_valid / cfg_ready, always ready, cfg_index selects
//  calibration offset, beta, series ohms, nominal ohms.
//  reset (arst_n low): sum and count cleared, registers to their defaults,
//  no result pending.
module thermistor_beta_temperature_unit
	import tbt_pkg::*;
#(
	parameter int SAMPLES_PER_READING = 10,
	parameter int ADC_BITS            = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [11:0]        adc_sample,
	input  logic               sample_valid,
	output logic               sample_stall,
	output logic signed [14:0] temp_f_sixteenths,
	output logic               out_of_range,
	output logic               result_valid,
	input  logic               result_stall,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data
);

	localparam int          FULL  = SAMPLES_PER_READING * ((1 << ADC_BITS) - 1);
	localparam int          SUM_W = $clog2(FULL + 1);
	localparam int          CNT_W = $clog2(SAMPLES_PER_READING + 1);
	localparam logic [11:0] MASK  = (ADC_BITS >= 12) ? 12'hFFF
		: 12'((1 << ADC_BITS) - 1);

	state_t state_q;

	logic [SUM_W-1:0] sum_q, s_q;
	logic [CNT_W-1:0] cnt_q;

	logic signed [11:0] cal_q;
	logic [13:0]        beta_q;
	logic [19:0]        series_q, nominal_q;

	logic [31:0]        m_q;
	logic [4:0]         k_q;
	logic [19:0]        f_q;
	logic [4:0]         it_q;
	logic [1:0]         lidx_q;
	logic signed [27:0] acc_q;
	logic [26:0]        xmag_q;
	logic               xneg_q;
	logic signed [47:0] d_q;
	logic [63:0]        quo_q;
	logic [46:0]        rem_q;
	logic [45:0]        dvs_q;
	logic [6:0]         dcnt_q;
	logic               out_valid_q;
	logic [14:0]        res_q;
	logic               flag_q;
	logic [14:0]        out_res_q;
	logic               out_flag_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	logic [SUM_W-1:0] samp_ext, sum_next;
	logic             accept;
	logic             out_free;
	logic [31:0]      log_opnd;
	logic [31:0]      sq_t;
	logic [19:0]      f_next;
	logic [24:0]      log_val;
	logic [26:0]      acc_mag;
	logic signed [47:0] d_calc;
	logic [46:0]      rsh;
	logic             rge;
	logic             v_big;
	logic signed [49:0] w_val;
	logic signed [40:0] y_val;
	logic [19:0]      y_off;
	logic             degenerate;

	assign cfg_ready         = 1'b1;
	assign sample_stall      = (state_q != ST_IDLE);
	assign accept            = sample_valid && !sample_stall;
	assign result_valid      = out_valid_q;
	assign temp_f_sixteenths = out_res_q;
	assign out_of_range      = out_flag_q;
	assign out_free          = !out_valid_q || !result_stall;

	assign samp_ext = SUM_W'(adc_sample & MASK);
	assign sum_next = sum_q + samp_ext;

	assign degenerate = (s_q == '0) || ({10'd0, s_q} >= 32'(FULL))
		|| (series_q == '0) || (nominal_q == '0);

	// log operand for each of the four terms
	always_comb begin
		case (lidx_q)
			2'd0:    log_opnd = 32'(series_q);
			2'd1:    log_opnd = 32'(s_q);
			2'd2:    log_opnd = 32'(nominal_q);
			default: log_opnd = 32'(FULL) - 32'(s_q);
		endcase
	end

	// multiplier operand selection
	always_comb begin
		case (state_q)
			ST_SQR:   begin mul_a = m_q;             mul_b = m_q;       end
			ST_LN:    begin mul_a = 32'(acc_mag);    mul_b = LN2_Q24;   end
			ST_XMUL:  begin mul_a = 32'(xmag_q);     mul_b = T0_X100;   end
			ST_DCALC: begin mul_a = 32'(beta_q);     mul_b = NUM_SCALE; end
			ST_FIN:   begin mul_a = quo_q[31:0];     mul_b = RECIP_25;  end
			default:  begin mul_a = '0;              mul_b = '0;        end
		endcase
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// squaring step of the log2 fraction
	assign sq_t    = mul_p[61:30];
	assign f_next  = {f_q[18:0], sq_t[31]};
	assign log_val = {k_q, f_next};
	assign acc_mag = acc_q[27] ? 27'(-acc_q) : 27'(acc_q);

	// denominator 100*beta*2^20 + 29815*x
	always_comb begin
		d_calc = $signed({7'd0, 21'(beta_q * 21'd100), 20'd0});
		if (xneg_q)
			d_calc = d_calc - $signed({7'd0, mul_p[40:0]});
		else
			d_calc = d_calc + $signed({7'd0, mul_p[40:0]});
	end

	// restoring divider step
	assign rsh = {rem_q[45:0], quo_q[63]};
	assign rge = rsh >= {1'b0, dvs_q};

	// final scaling ahead of the divide by 25
	assign v_big = (|quo_q[63:41]) || (quo_q[40] && (|quo_q[39:0]));
	always_comb begin
		w_val = $signed({9'd0, quo_q[40:0]}) * 50'sd100 - 50'sd94140416
			+ 50'(cal_q) * 50'sd12800 + 50'sd6400;
		y_val = 41'(w_val >>> 9);
		y_off = 20'(y_val + 41'sd204800);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q     <= '0;
			beta_q    <= 14'd3950;
			series_q  <= 20'd100000;
			nominal_q <= 20'd100000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAL_OFFSET: cal_q     <= cfg_data[11:0];
				REG_BETA:       beta_q    <= cfg_data[13:0];
				REG_SERIES:     series_q  <= cfg_data;
				REG_NOMINAL:    nominal_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
			out_flag_q  <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
			out_res_q   <= res_q;
			out_flag_q  <= flag_q;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cnt_q + CNT_W'(1) < CNT_W'(SAMPLES_PER_READING)) begin
							sum_q <= sum_next;
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					if (degenerate)
						state_q <= ST_OUT;
					else
						state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (m_q[30])
						state_q <= ST_SQR;
				end
				ST_SQR: begin
					if (it_q == 5'(LOG_ITERS - 1)) begin
						if (lidx_q == 2'd3)
							state_q <= ST_LN;
						else
							state_q <= ST_NORM;
					end
				end
				ST_LN:    state_q <= ST_XMUL;
				ST_XMUL:  state_q <= ST_DCALC;
				ST_DCALC: begin
					if (d_q[47] || d_q == '0)
						state_q <= ST_OUT;
					else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dcnt_q == 7'(DIV_ITERS - 1))
						state_q <= ST_POST;
				end
				ST_POST: begin
					if (v_big || y_val >= 41'sd409600 || y_val < -41'sd204800)
						state_q <= ST_OUT;
					else
						state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				s_q    <= sum_next;
				lidx_q <= 2'd0;
			end
			ST_START: begin
				acc_q  <= '0;
				m_q    <= log_opnd;
				k_q    <= 5'd30;
				f_q    <= '0;
				it_q   <= '0;
				res_q  <= 15'd0;
				flag_q <= 1'b1;
			end
			ST_NORM: begin
				if (!m_q[30]) begin
					m_q <= {m_q[30:0], 1'b0};
					k_q <= k_q - 5'd1;
				end
			end
			ST_SQR: begin
				m_q  <= sq_t[31] ? {1'b0, sq_t[31:1]} : sq_t;
				f_q  <= f_next;
				it_q <= it_q + 5'd1;
				if (it_q == 5'(LOG_ITERS - 1)) begin
					if (lidx_q[1])
						acc_q <= acc_q - $signed({3'd0, log_val});
					else
						acc_q <= acc_q + $signed({3'd0, log_val});
					lidx_q <= lidx_q + 2'd1;
					it_q   <= '0;
					f_q    <= '0;
					k_q    <= 5'd30;
					case (lidx_q)
						2'd0:    m_q <= 32'(s_q);
						2'd1:    m_q <= 32'(nominal_q);
						default: m_q <= 32'(FULL) - 32'(s_q);
					endcase
				end
			end
			ST_LN: begin
				xmag_q <= 27'((mul_p + 64'd8388608) >> 24);
				xneg_q <= acc_q[27];
			end
			ST_XMUL: begin
				d_q <= d_calc;
			end
			ST_DCALC: begin
				res_q   <= OUT_MAX;
				flag_q  <= 1'b1;
				quo_q   <= {mul_p[36:0], 27'd0};
				rem_q   <= '0;
				dvs_q   <= 46'(d_q[43:0]) * 46'd5;
				dcnt_q  <= '0;
			end
			ST_DIV: begin
				rem_q  <= rge ? (rsh - {1'b0, dvs_q}) : rsh;
				quo_q  <= {quo_q[62:0], rge};
				dcnt_q <= dcnt_q + 7'd1;
			end
			ST_POST: begin
				res_q   <= (v_big || y_val >= 41'sd409600) ? OUT_MAX : OUT_MIN;
				flag_q  <= 1'b1;
				quo_q   <= 64'(y_off);
			end
			// offset quotient by 25 through the reciprocal, exact below 2^20
			ST_FIN: begin
				res_q  <= 15'(mul_p[40:25] - 16'd8192);
				flag_q <= 1'b0;
			end
			default: ;
		endcase
	end

endmodule

// ===== dv/tb_thermistor_beta_temperature_unit.sv =====
// tb_thermistor_beta_temperature_unit: self-checking bench for the thermistor beta unit
// predicts each reading in fixed point and checks it against the unit's output
// depends on tbt_pkg and thermistor_beta_temperature_unit
`timescale 1ns / 1ps

module tb_thermistor_beta_temperature_unit
	import tbt_pkg::*;
;

	localparam int RUN_LEN = 10;
	localparam int FULL_SCALE = RUN_LEN * 4095;

	// expected readings and predictor state
	class reading_scoreboard;
		logic [14:0] temp_q[$];
		logic        flag_q[$];
		int          failures;
		int          checked;
		int          cal_offset;
		longint      beta;
		longint      series;
		longint      nominal;
		int          run_sum;
		int          run_count;

		function new();
			failures = 0;
			checked = 0;
			cal_offset = 0;
			beta = 3950;
			series = 100000;
			nominal = 100000;
			run_sum = 0;
			run_count = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [19:0] data);
			case (idx)
				REG_CAL_OFFSET: cal_offset = $signed(data[11:0]);
				REG_BETA:       beta = data[13:0];
				REG_SERIES:     series = data;
				REG_NOMINAL:    nominal = data;
				default: ;
			endcase
		endfunction

		// log2 with 20 fractional bits by repeated squaring
		function longint log2_fix(longint v);
			int k;
			longint unsigned m;
			longint f;
			k = 31;
			f = 0;
			while (k > 0 && v[k] == 1'b0)
				k--;
			if (k <= 30)
				m = longint'(v) << (30 - k);
			else
				m = longint'(v) >> (k - 30);
			for (int i = 0; i < 20; i++) begin
				m = (m * m) >> 30;
				f = f << 1;
				if (m >= (64'd1 << 31)) begin
					m = m >> 1;
					f = f | 1;
				end
			end
			return (longint'(k) << 20) | f;
		endfunction

		function void predict(longint s);
			longint l, x, d, w, q;
			longint unsigned mag, num, v;
			logic fl;
			fl = 1'b0;
			if (s == 0 || s >= FULL_SCALE || series == 0 || nominal == 0) begin
				temp_q.push_back(15'd0);
				flag_q.push_back(1'b1);
				return;
			end
			l = log2_fix(series) + log2_fix(s) - log2_fix(nominal) - log2_fix(FULL_SCALE - s);
			mag = (l < 0) ? -l : l;
			mag = (mag * 64'd11629080 + (64'd1 << 23)) >> 24;
			x = (l < 0) ? -longint'(mag) : longint'(mag);
			d = ((100 * beta) << 20) + 29815 * x;
			if (d <= 0) begin
				temp_q.push_back(OUT_MAX);
				flag_q.push_back(1'b1);
				return;
			end
			num = (64'd4293360 * longint'(beta)) << 27;
			v = num / (longint'(d) * 5);
			if (v > (64'd1 << 40)) begin
				temp_q.push_back(OUT_MAX);
				flag_q.push_back(1'b1);
				return;
			end
			w = longint'(v) * 100 - 94140416 + longint'(cal_offset) * 12800;
			w = w + 6400;
			q = (w >= 0) ? w / 12800 : -((-w + 12799) / 12800);
			if (q > 16383) begin q = 16383; fl = 1'b1; end
			if (q < -8192) begin q = -8192; fl = 1'b1; end
			temp_q.push_back(q[14:0]);
			flag_q.push_back(fl);
		endfunction

		function void note_sample(logic [11:0] smp);
			run_sum += smp;
			if (run_count + 1 < RUN_LEN) begin
				run_count++;
				return;
			end
			predict(run_sum);
			run_sum = 0;
			run_count = 0;
		endfunction

		function void check_reading(logic [14:0] t, logic fl);
			logic [14:0] et;
			logic ef;
			if (temp_q.size() == 0) begin
				$display("%0t: unexpected reading temp=%0d flag=%0b", $time, $signed(t), fl);
				failures++;
				return;
			end
			et = temp_q.pop_front();
			ef = flag_q.pop_front();
			checked++;
			if (et !== t) begin
				$display("%0t: temp mismatch expected %0d actual %0d", $time,
					$signed(et), $signed(t));
				failures++;
			end
			if (ef !== fl) begin
				$display("%0t: flag mismatch expected %0b actual %0b", $time, ef, fl);
				failures++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic [11:0]        adc_sample;
	logic               sample_valid;
	logic               sample_stall;
	logic signed [14:0] temp_f_sixteenths;
	logic               out_of_range;
	logic               result_valid;
	logic               result_stall;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [19:0]        cfg_data;

	reading_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;
	int samples_sent;

	thermistor_beta_temperature_unit DUT (
		.clk(clk), .arst_n(arst_n), .adc_sample(adc_sample),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.temp_f_sixteenths(temp_f_sixteenths), .out_of_range(out_of_range),
		.result_valid(result_valid), .result_stall(result_stall),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// timeout
	initial begin
		#40000000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stalls, long hold-off on request, checking
	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall)
				sb.check_reading(temp_f_sixteenths, out_of_range);
			result_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// one item on the sample channel, with random idle cycles first
	task automatic send_sample(logic [11:0] smp);
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		adc_sample <= smp;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sb.note_sample(smp);
		samples_sent++;
	endtask

	// a full run with every sample near one level
	task automatic send_run(int level, int spread);
		int v;
		for (int i = 0; i < RUN_LEN; i++) begin
			v = level + $urandom_range(2 * spread) - spread;
			if (v < 0) v = 0;
			if (v > 4095) v = 4095;
			send_sample(v[11:0]);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [19:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// wait for all readings, then let the sequencer drain
	task automatic drain();
		sample_valid <= 1'b0;
		while (sb.temp_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic random_phase(int n_runs);
		for (int r = 0; r < n_runs; r++) begin
			if ($urandom_range(9) == 0)
				for (int i = 0; i < RUN_LEN; i++)
					send_sample(12'($urandom));
			else
				send_run($urandom_range(4095), $urandom_range(1) ? 3 : 200);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		adc_sample = '0;
		sample_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CAL_OFFSET;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		samples_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, zero sum, full scale, extremes, mid values
		for (int i = 0; i < RUN_LEN; i++) send_sample(12'd0);
		for (int i = 0; i < RUN_LEN; i++) send_sample(12'hFFF);
		send_run(2048, 0);
		drain();
		// hottest and coldest with extreme registers, saturation both ways
		write_reg(REG_CAL_OFFSET, 20'hFF800);
		write_reg(REG_BETA, 20'd1000);
		write_reg(REG_SERIES, 20'd1);
		write_reg(REG_NOMINAL, 20'd1000000);
		send_run(4094, 0);
		send_run(1, 0);
		drain();
		write_reg(REG_CAL_OFFSET, 20'd2047);
		write_reg(REG_BETA, 20'd10000);
		write_reg(REG_SERIES, 20'd1000000);
		write_reg(REG_NOMINAL, 20'd1);
		send_run(1, 0);
		send_run(4094, 0);
		drain();
		// zero resistors and zero beta
		write_reg(REG_SERIES, 20'd0);
		send_run(2000, 0);
		drain();
		write_reg(REG_SERIES, 20'd100000);
		write_reg(REG_NOMINAL, 20'd0);
		send_run(2000, 0);
		drain();
		write_reg(REG_NOMINAL, 20'd100000);
		write_reg(REG_BETA, 20'd0);
		send_run(100, 0);
		send_run(4000, 0);
		drain();
		write_reg(REG_BETA, 20'hFFFFF);
		write_reg(REG_CAL_OFFSET, 20'd0);
		send_run(2048, 0);
		drain();

		// random phases over several register settings and idling mixes
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			write_reg(REG_CAL_OFFSET, 20'($urandom));
			write_reg(REG_BETA, 20'($urandom_range(10000, 1000)));
			write_reg(REG_SERIES, 20'($urandom_range(1000000, 1)));
			write_reg(REG_NOMINAL, 20'($urandom_range(1000000, 1)));
			if (ph == 4) begin
				// receiver holds off while samples keep coming
				hold_off = 1'b1;
				fork
					begin
						repeat (3000) @(posedge clk);
						hold_off = 1'b0;
					end
					random_phase(4);
				join
			end
			random_phase(12);
			drain();
		end

		$display("%0d samples sent, %0d readings checked across reset and random settings",
			samples_sent, sb.checked);
		if (sb.failures == 0 && sb.temp_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
